@@ sv/irff_pkg.sv @@
package irff_pkg;

    // field widths
    localparam int TIME_W    = 32;
    localparam int ANGLE_W   = 25;
    localparam int GYRO_W    = 28;
    localparam int COEFF_W   = 16;
    localparam int DIFF_W    = ANGLE_W + 1;
    localparam int HPX_W     = 34;

    // shared multiplier operand and product widths
    localparam int MUL_A_W   = 34;
    localparam int MUL_B_W   = 28;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

    // divider: magnitude of angle step times 1e6 stays below 2^45
    localparam int DIV_N_W   = 45;
    localparam int DIV_D_W   = 32;
    localparam int DIV_STEPS = DIV_N_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // configuration register indexes
    localparam logic [1:0] REG_LOWPASS_COEFF  = 2'd0;
    localparam logic [1:0] REG_HIGHPASS_COEFF = 2'd1;
    localparam logic [1:0] REG_MIN_DT_US      = 2'd2;

    // opcodes
    localparam logic OP_SEED   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // arithmetic constants
    localparam logic [MUL_B_W-1:0] USEC_PER_SEC = 28'd1000000;
    localparam logic [MUL_B_W-1:0] DEG2RAD_Q32  = 28'd74961321;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL_DIFF,
        ST_DIV_START,
        ST_LP_IN,
        ST_LP_OUT,
        ST_HP,
        ST_SUM,
        ST_FUSE,
        ST_FUSED,
        ST_WAIT_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               sat;
    } sat32_t;

    // clamp a wide signed value to 32 bits, flagging any clamp
    function automatic sat32_t sat32(input logic signed [63:0] v);
        sat32_t r;
        r.sat = 1'b0;
        if (v > 64'sd2147483647)
        begin
            r.value = 32'sh7fffffff;
            r.sat   = 1'b1;
        end
        else if (v < -64'sd2147483648)
        begin
            r.value = 32'sh80000000;
            r.sat   = 1'b1;
        end
        else
        begin
            r.value = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ sv/irff_mul.sv @@
module irff_mul
    import irff_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [MUL_P_W-1:0] prod
);

    logic signed [MUL_P_W-1:0] prod_reg;

    // shared signed multiplier, product registered every cycle
    always_ff @(posedge clk)
    begin
        prod_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign prod = prod_reg;

endmodule

@@ sv/irff_div.sv @@
module irff_div
    import irff_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic               busy,
    output logic [DIV_N_W-1:0] quotient
);

    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_D_W-1:0]   rem_next;
    logic [DIV_N_W-1:0]   quo_reg;
    logic [DIV_N_W-1:0]   quo_next;
    logic [DIV_D_W-1:0]   den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic [DIV_D_W:0]     trial;
    logic                 fits;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIV_N_W-1]};
        fits     = trial >= {1'b0, den_reg};
        rem_next = fits ? DIV_D_W'(trial - {1'b0, den_reg}) : trial[DIV_D_W-1:0];
        quo_next = {quo_reg[DIV_N_W-2:0], fits};
        cnt_next = cnt_reg - DIV_CNT_W'(1);
        busy_next = (cnt_reg != DIV_CNT_W'(1));
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
        end
        else if (busy_reg)
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

@@ sv/imu_rate_fusion_filter.sv @@
// sample word: result offered once the restoring divider finishes and the output register is free
// seed word: taken without leaving idle, gives no result
// one word at a time: after a sample, next word taken once its result is registered, later while a result waits
// rst_n (asynchronous, active low) restores the default coefficients and
// clears the previous time, angle and filter history
module imu_rate_fusion_filter
    import irff_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // time_us[31:0], acc_angle[56:32], gyro_rate[84:57], zeros
    input  logic        s_tuser,   // opcode
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // fused_rate[31:0]
    output logic        m_tuser    // rate_saturated
);

    state_t state_reg;
    state_t state_next;

    // configuration
    logic [COEFF_W-1:0] lp_coeff_reg;
    logic [COEFF_W-1:0] hp_coeff_reg;
    logic [15:0]        min_dt_reg;

    // history
    logic [TIME_W-1:0]         last_time_reg;
    logic signed [ANGLE_W-1:0] last_angle_reg;
    logic signed [31:0]        lp_in_reg;
    logic signed [31:0]        lp_out_reg;
    logic signed [GYRO_W-1:0]  hp_in_reg;
    logic signed [31:0]        hp_out_reg;

    // latched word and working registers
    logic [TIME_W-1:0]         time_reg;
    logic signed [ANGLE_W-1:0] angle_reg;
    logic signed [GYRO_W-1:0]  gyro_reg;
    logic [TIME_W-1:0]         dt_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [HPX_W-1:0]   hpx_reg;
    logic signed [MUL_P_W-1:0] mac_reg;
    logic signed [31:0]        lp_reg;
    logic signed [31:0]        hp_reg;
    logic signed [31:0]        sum_reg;
    logic signed [31:0]        fused_reg;
    logic                      div_neg_reg;
    logic                      sat_reg;

    // output register
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic        m_tuser_reg;

    // shared units
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;
    logic                      div_start;
    logic                      div_busy;
    logic [DIV_N_W-1:0]        quotient;
    logic [DIV_N_W-1:0]        dividend_abs;

    // combinational datapath terms
    logic                      in_accept;
    logic                      out_free;
    logic [TIME_W-1:0]         dt_raw;
    logic [TIME_W-1:0]         dt_floor;
    logic signed [MUL_P_W-1:0] lp_round;
    logic signed [MUL_P_W-1:0] hp_round;
    logic signed [MUL_P_W-1:0] fused_round;
    logic [63:0]               rate_wide;
    sat32_t                    hp_sat;
    sat32_t                    sum_sat;
    sat32_t                    rate_sat;

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // configuration writes, always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_coeff_reg <= 16'd62259;
            hp_coeff_reg <= 16'd62259;
            min_dt_reg   <= 16'd10;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LOWPASS_COEFF:  lp_coeff_reg <= cfg_data;
                REG_HIGHPASS_COEFF: hp_coeff_reg <= cfg_data;
                REG_MIN_DT_US:      min_dt_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    // shared units
    irff_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // magnitude of the scaled angle step, below 2^45
    assign dividend_abs = prod[MUL_P_W-1] ? (DIV_N_W'(0) - prod[DIV_N_W-1:0])
                                          : prod[DIV_N_W-1:0];

    irff_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend_abs),
        .divisor  (dt_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (s_tuser == OP_SAMPLE))
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:      state_next = ST_MUL_DIFF;
            ST_MUL_DIFF:  state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_LP_IN;
            ST_LP_IN:     state_next = ST_LP_OUT;
            ST_LP_OUT:    state_next = ST_HP;
            ST_HP:        state_next = ST_SUM;
            ST_SUM:       state_next = ST_FUSE;
            ST_FUSE:      state_next = ST_FUSED;
            ST_FUSED:     state_next = ST_WAIT_DIV;
            ST_WAIT_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // outputs of the sequencer: handshake, multiplier operands, divider start
    always_comb
    begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_MUL_DIFF:
            begin
                mul_a = {{(MUL_A_W-DIFF_W){diff_reg[DIFF_W-1]}}, diff_reg};
                mul_b = USEC_PER_SEC;
            end
            ST_DIV_START:
            begin
                div_start = 1'b1;
                mul_a     = {{(MUL_A_W-32){lp_in_reg[31]}}, lp_in_reg};
                mul_b     = MUL_B_W'(17'h10000 - {1'b0, lp_coeff_reg});
            end
            ST_LP_IN:
            begin
                mul_a = {{(MUL_A_W-32){lp_out_reg[31]}}, lp_out_reg};
                mul_b = MUL_B_W'(lp_coeff_reg);
            end
            ST_LP_OUT:
            begin
                mul_a = hpx_reg;
                mul_b = MUL_B_W'(hp_coeff_reg);
            end
            ST_FUSE:
            begin
                mul_a = {{(MUL_A_W-32){sum_reg[31]}}, sum_reg};
                mul_b = DEG2RAD_Q32;
            end
            default:
            begin
            end
        endcase
    end

    // time step with wrap and floor
    always_comb
    begin
        dt_raw   = time_reg - last_time_reg;
        dt_floor = (dt_raw < {16'd0, min_dt_reg}) ? {16'd0, min_dt_reg} : dt_raw;
        if (dt_floor == '0)
        begin
            dt_floor = TIME_W'(1);
        end
    end

    // rounding, clamping and the signed derivative
    always_comb
    begin
        lp_round    = mac_reg + prod + MUL_P_W'(32768);
        hp_round    = prod + MUL_P_W'(32768);
        fused_round = prod + MUL_P_W'(64'h80000000);
        hp_sat      = sat32({{18{hp_round[MUL_P_W-1]}}, hp_round[MUL_P_W-1:16]});
        sum_sat     = sat32({{32{lp_reg[31]}}, lp_reg} + {{32{hp_reg[31]}}, hp_reg});
        rate_wide   = div_neg_reg ? (64'd0 - {{(64-DIV_N_W){1'b0}}, quotient})
                                  : {{(64-DIV_N_W){1'b0}}, quotient};
        rate_sat    = sat32(rate_wide);
    end

    // history registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg  <= '0;
            last_angle_reg <= '0;
            lp_in_reg      <= '0;
            lp_out_reg     <= '0;
            hp_in_reg      <= '0;
            hp_out_reg     <= '0;
        end
        else
        begin
            if (in_accept && (s_tuser == OP_SEED))
            begin
                last_time_reg  <= s_tdata[31:0];
                last_angle_reg <= s_tdata[56:32];
            end
            else if (state_reg == ST_PREP)
            begin
                last_time_reg  <= time_reg;
                last_angle_reg <= angle_reg;
            end
            else if ((state_reg == ST_WAIT_DIV) && !div_busy)
            begin
                lp_in_reg  <= rate_sat.value;
                lp_out_reg <= lp_reg;
                hp_in_reg  <= gyro_reg;
                hp_out_reg <= hp_reg;
            end
        end
    end

    // working datapath
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            time_reg  <= s_tdata[31:0];
            angle_reg <= s_tdata[56:32];
            gyro_reg  <= s_tdata[84:57];
        end
        unique case (state_reg)
            ST_PREP:
            begin
                dt_reg   <= dt_floor;
                diff_reg <= DIFF_W'(angle_reg) - DIFF_W'(last_angle_reg);
                hpx_reg  <= HPX_W'(hp_out_reg) + HPX_W'(gyro_reg) - HPX_W'(hp_in_reg);
                sat_reg  <= 1'b0;
            end
            ST_DIV_START:
            begin
                div_neg_reg <= prod[MUL_P_W-1];
            end
            ST_LP_IN:
            begin
                mac_reg <= prod;
            end
            ST_LP_OUT:
            begin
                lp_reg <= lp_round[47:16];
            end
            ST_HP:
            begin
                hp_reg  <= hp_sat.value;
                sat_reg <= sat_reg | hp_sat.sat;
            end
            ST_SUM:
            begin
                sum_reg <= sum_sat.value;
                sat_reg <= sat_reg | sum_sat.sat;
            end
            ST_FUSED:
            begin
                fused_reg <= {{2{fused_round[MUL_P_W-1]}}, fused_round[MUL_P_W-1:32]};
            end
            ST_WAIT_DIV:
            begin
                if (!div_busy)
                begin
                    sat_reg <= sat_reg | rate_sat.sat;
                end
            end
            default:
            begin
            end
        endcase
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if ((state_reg == ST_OUT) && out_free)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_OUT) && out_free)
        begin
            m_tdata_reg <= fused_reg;
            m_tuser_reg <= sat_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ sim/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import irff_pkg::*;

    localparam int          ACC_LIMIT    = 11796480;
    localparam int          GYRO_LIMIT   = 131072000;
    localparam logic [15:0] COEFF_RESET  = 16'd62259;
    localparam logic [15:0] FLOOR_RESET  = 16'd10;
    localparam logic [1:0]  REG_UNUSED   = 2'd3;
    localparam int          DRAIN_CYCLES = 64;

    // one fused rate word as it leaves the block
    typedef struct packed {
        logic signed [31:0] rate;
        logic               sat;
    } fusion_word_t;

    // predicts the fused rate of every accepted sample word and checks results in order
    class fusion_scoreboard;
        fusion_word_t expected_q[$];
        int           errors;
        logic [15:0]  alpha;
        logic [15:0]  beta;
        logic [15:0]  floor_us;
        logic [31:0]  prev_time;
        int           prev_angle;
        int           lp_in;
        int           lp_out;
        int           hp_in;
        int           hp_out;

        function new();
            errors     = 0;
            alpha      = COEFF_RESET;
            beta       = COEFF_RESET;
            floor_us   = FLOOR_RESET;
            prev_time  = '0;
            prev_angle = 0;
            lp_in      = 0;
            lp_out     = 0;
            hp_in      = 0;
            hp_out     = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] value);
            case (idx)
                REG_LOWPASS_COEFF:  alpha = value;
                REG_HIGHPASS_COEFF: beta = value;
                REG_MIN_DT_US:      floor_us = value;
                default: ;
            endcase
        endfunction

        // right shift with ties toward plus infinity
        function longint round_shift(longint v, int n);
            return (v + (longint'(1) << (n - 1))) >>> n;
        endfunction

        function int clamp32(longint v, inout bit sat);
            if (v > 64'sd2147483647)
            begin
                sat = 1'b1;
                return 32'sh7fffffff;
            end
            if (v < -64'sd2147483648)
            begin
                sat = 1'b1;
                return 32'sh80000000;
            end
            return int'(v);
        endfunction

        function void note_input(logic op, logic [31:0] stamp, logic [24:0] acc_bits,
                                 logic [27:0] gyro_bits);
            longint       acc;
            longint       gyro;
            longint       a;
            longint       b;
            longint       usec;
            longint       deg2rad;
            longint       step_l;
            longint       fused;
            logic [31:0]  step;
            int           deriv;
            int           lp;
            int           hp;
            int           sum;
            bit           sat;
            fusion_word_t want;

            acc     = longint'($signed(acc_bits));
            gyro    = longint'($signed(gyro_bits));
            usec    = longint'(USEC_PER_SEC);
            deg2rad = longint'(DEG2RAD_Q32);
            a       = longint'(alpha);
            b       = longint'(beta);
            sat     = 1'b0;

            // seed word only loads the previous time and angle
            if (op == OP_SEED)
            begin
                prev_time  = stamp;
                prev_angle = int'(acc);
                return;
            end

            // time step, modulo 2^32, with floor and a floor of one
            step = stamp - prev_time;
            if (step < floor_us)
                step = 32'(floor_us);
            if (step == 0)
                step = 32'd1;
            step_l    = longint'(step);
            prev_time = stamp;

            // angle derivative in deg/s
            deriv      = clamp32((acc - prev_angle) * usec / step_l, sat);
            prev_angle = int'(acc);

            // low-pass on the previous derivative
            lp     = int'(round_shift((65536 - a) * lp_in + a * lp_out, 16));
            lp_in  = deriv;
            lp_out = lp;

            // high-pass on the gyro rate
            hp     = clamp32(round_shift(b * (hp_out + gyro - hp_in), 16), sat);
            hp_in  = int'(gyro);
            hp_out = hp;

            // sum and scale to rad/s
            sum   = clamp32(longint'(lp) + hp, sat);
            fused = round_shift(sum * deg2rad, 32);

            want.rate = fused[31:0];
            want.sat  = sat;
            expected_q.push_back(want);
        endfunction

        function void check_result(logic signed [31:0] rate, logic sat);
            fusion_word_t want;
            if (expected_q.size() == 0)
            begin
                if (errors < 10)
                    $display("result with nothing pending: fused_rate %0d rate_saturated %0b",
                             rate, sat);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (rate !== want.rate || sat !== want.sat)
            begin
                if (errors < 10)
                    $display("mismatch: fused_rate exp %0d got %0d, rate_saturated exp %0b got %0b",
                             want.rate, rate, want.sat, sat);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;   // time_us[31:0], acc_angle[56:32], gyro_rate[84:57], zeros
    logic        s_tuser;   // opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // fused_rate[31:0]
    logic        m_tuser;   // rate_saturated

    bit          no_idle;
    logic [31:0] stream_time;
    int          stream_angle;

    fusion_scoreboard sb = new();

    always #5 clk = ~clk;

    imu_rate_fusion_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // present one input word after a random gap and wait for it to be taken
    task automatic send_item(input logic op, input logic [31:0] stamp,
                             input int acc, input int gyro);
        int          gap;
        logic [24:0] acc_bits;
        logic [27:0] gyro_bits;
        acc_bits  = 25'(acc);
        gyro_bits = 28'(gyro);
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tuser  <= op;
        s_tdata  <= {3'b000, gyro_bits, acc_bits, stamp};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        sb.note_input(op, stamp, acc_bits, gyro_bits);
    endtask

    // one register write word, valid left high for the caller
    task automatic cfg_word(input logic [1:0] idx, input logic [15:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, value);
    endtask

    task automatic write_regs(input logic [15:0] alpha, input logic [15:0] beta,
                              input logic [15:0] floor_us, input bit stray);
        // a write to the spare index must change nothing
        if (stray)
            cfg_word(REG_UNUSED, 16'($urandom));
        cfg_word(REG_LOWPASS_COEFF, alpha);
        cfg_word(REG_HIGHPASS_COEFF, beta);
        cfg_word(REG_MIN_DT_US, floor_us);
        cfg_valid <= 1'b0;
    endtask

    // stop sending, let every pending result arrive, then allow for a seed in flight
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // mostly plausible sample streams, with seeds and raw noise mixed in
    task automatic random_item();
        int          pick;
        int          acc;
        logic [24:0] acc_raw;
        int          gyro;
        logic [31:0] step;
        pick = $urandom_range(0, 99);
        if (pick < 6)
        begin
            stream_time  = $urandom;
            stream_angle = $urandom_range(0, 2 * ACC_LIMIT) - ACC_LIMIT;
            send_item(OP_SEED, stream_time, stream_angle, $urandom);
        end
        else if (pick < 12)
        begin
            send_item(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
        end
        else
        begin
            // time step: below the floor, huge and wrapping, short, or about a kilohertz
            case ($urandom_range(0, 9))
                0:       step = $urandom_range(0, 20);
                1:       step = $urandom;
                2:       step = $urandom_range(20, 500);
                default: step = $urandom_range(500, 5000);
            endcase
            stream_time = stream_time + step;

            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                acc = stream_angle + $urandom_range(0, 131072) - 65536;
                if (acc > ACC_LIMIT)
                    acc = ACC_LIMIT;
                if (acc < -ACC_LIMIT)
                    acc = -ACC_LIMIT;
            end
            else if (pick < 9)
                acc = $urandom_range(0, 2 * ACC_LIMIT) - ACC_LIMIT;
            else
            begin
                acc_raw = 25'($urandom);
                acc     = int'($signed(acc_raw));
            end
            stream_angle = acc;

            pick = $urandom_range(0, 9);
            if (pick < 8)
                gyro = $urandom_range(0, 2 * GYRO_LIMIT) - GYRO_LIMIT;
            else if (pick == 8)
                gyro = $urandom_range(0, 1) ? GYRO_LIMIT : -GYRO_LIMIT;
            else
                gyro = $urandom;

            send_item(OP_SAMPLE, stream_time, acc, gyro);
        end
    endtask

    // result side with random stalls
    initial
    begin : result_sink
        int stall;
        m_tready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sb.check_result(m_tdata, m_tuser);
        end
    end

    // stimulus
    initial
    begin
        rst_n        <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= OP_SEED;
        no_idle      = 1'b0;
        stream_time  = '0;
        stream_angle = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default coefficients: start-up, wrap, step floor and field extremes
        send_item(OP_SAMPLE, 32'd1000, ACC_LIMIT, GYRO_LIMIT);
        send_item(OP_SAMPLE, 32'd2000, -ACC_LIMIT, -GYRO_LIMIT);
        send_item(OP_SEED, 32'hFFFF_FF00, 0, 0);
        send_item(OP_SAMPLE, 32'h0000_0100, ACC_LIMIT, 0);
        send_item(OP_SAMPLE, 32'h0000_0100, -ACC_LIMIT, GYRO_LIMIT);
        send_item(OP_SAMPLE, 32'h0000_0105, 1 - ACC_LIMIT, -GYRO_LIMIT);
        send_item(OP_SAMPLE, 32'h0000_1000, 16777215, 134217727);
        send_item(OP_SAMPLE, 32'h0000_2000, -16777216, -134217728);
        send_item(OP_SEED, 32'hFFFF_FFFF, -1, -1);
        send_item(OP_SAMPLE, 32'h0000_0000, -1, 0);
        send_item(OP_SAMPLE, 32'd1000000, 65536, 655360);
        for (int i = 1; i <= 2; i++)
            send_item(OP_SAMPLE, 1000000 + 1000 * i, 65536 + 3000 * i, 655360 - 50000 * i);

        // no low-pass smoothing, full high-pass, unit floor: clamps on every path
        drain();
        write_regs(16'd0, 16'hFFFF, 16'd1, 1'b1);
        send_item(OP_SEED, 32'd100, -ACC_LIMIT, 0);
        send_item(OP_SAMPLE, 32'd101, ACC_LIMIT, GYRO_LIMIT);
        send_item(OP_SAMPLE, 32'd102, ACC_LIMIT, GYRO_LIMIT);
        send_item(OP_SAMPLE, 32'd103, -ACC_LIMIT, -GYRO_LIMIT);
        send_item(OP_SAMPLE, 32'd104, -ACC_LIMIT, -GYRO_LIMIT);

        // zero floor: a zero step is raised to one
        drain();
        write_regs(16'hFFFF, 16'd0, 16'd0, 1'b0);
        send_item(OP_SEED, 32'd500, 0, 0);
        send_item(OP_SAMPLE, 32'd500, 1000, GYRO_LIMIT);
        send_item(OP_SAMPLE, 32'd501, -1000, -GYRO_LIMIT);
        send_item(OP_SAMPLE, 32'd10000, 0, 0);

        // top of every register
        drain();
        write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_item(OP_SAMPLE, 32'd20000, ACC_LIMIT, GYRO_LIMIT);
        send_item(OP_SAMPLE, 32'd200000, -ACC_LIMIT, 0);
        send_item(OP_SAMPLE, 32'd300000, 0, -GYRO_LIMIT);

        // random phases, each under its own register setting
        for (int phase = 0; phase < 6; phase++)
        begin
            drain();
            case (phase)
                0:       write_regs(COEFF_RESET, COEFF_RESET, FLOOR_RESET, 1'b0);
                1:       write_regs(16'($urandom), 16'($urandom),
                                    16'($urandom_range(1, 20)), 1'b1);
                default: write_regs(16'($urandom), 16'($urandom),
                                    16'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                                                    : $urandom_range(1, 2000)),
                                    1'b0);
            endcase
            no_idle = (phase == 2 || phase == 4);
            repeat (100) random_item();
        end

        drain();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // hang guard
    initial
    begin
        #3_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
